>>> design/graph_sequence_edit_distance_top_defines.svh
// Assertion macros for the graph sequence edit distance block.
// Used by the top level only; no dependencies.
`ifndef GRAPH_SEQUENCE_EDIT_DISTANCE_TOP_DEFINES_SVH
`define GRAPH_SEQUENCE_EDIT_DISTANCE_TOP_DEFINES_SVH

// Same-cycle implication on clk, disabled during reset
`define GSED_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication on clk, disabled during reset
`define GSED_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/gsed_pkg.sv
// Shared codes and controller/datapath interface types for the graph
// sequence edit distance block. No dependencies.
package gsed_pkg;

	// input opcodes
	localparam logic [1:0] OP_LETTER = 2'd0;
	localparam logic [1:0] OP_EDGE   = 2'd1;
	localparam logic [1:0] OP_CHAR   = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	// result status codes
	localparam logic [1:0] STS_READY = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_ORDER = 2'd2;

	typedef struct packed {
		logic item_load;
		logic letter_wr;
		logic cnt_rd_edge;
		logic edge_wr;
		logic node_first;
		logic node_next;
		logic node_rd;
		logic node_eval;
		logic pred_rd;
		logic pred_eval;
		logic row_eval;
		logic node_wr;
		logic copy_clr;
		logic copy_step;
		logic rn_inc;
		logic rn_clr;
		logic res_full;
		logic res_order;
		logic res_dist;
		logic out_load;
		logic clr_clr;
		logic clr_step;
		logic clr_prev;
		logic clr_cnt;
	} gsed_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       node_ok;
		logic       pred_bad;
		logic       cnt_full;
		logic       cnt_zero;
		logic       k_last;
		logic       j_last;
		logic       last;
		logic       copy_done;
		logic       clr_last;
		logic       out_free;
	} gsed_stat_t;

endpackage

>>> design/gsed_ctrl.sv
// Controller state machine for the graph sequence edit distance block.
// Depends on gsed_pkg for opcodes and the command/status structs.
module gsed_ctrl
	import gsed_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  gsed_stat_t stat,
	output logic       idle,
	output gsed_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_DECODE    = 4'd1;
	localparam logic [3:0] S_EDGE      = 4'd2;
	localparam logic [3:0] S_NODE_RD   = 4'd3;
	localparam logic [3:0] S_NODE_EVAL = 4'd4;
	localparam logic [3:0] S_PRED_RD   = 4'd5;
	localparam logic [3:0] S_PRED_EVAL = 4'd6;
	localparam logic [3:0] S_ROW_EVAL  = 4'd7;
	localparam logic [3:0] S_WRITE     = 4'd8;
	localparam logic [3:0] S_COPY      = 4'd9;
	localparam logic [3:0] S_RESULT    = 4'd10;
	localparam logic [3:0] S_EMIT      = 4'd11;
	localparam logic [3:0] S_CLEAR     = 4'd12;

	logic [3:0] state_q, state_d;
	logic       clr_prev_q, clr_prev_d;
	logic       clr_cnt_q, clr_cnt_d;
	logic       go_clear_q, go_clear_d;

	assign idle = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		clr_prev_d = clr_prev_q;
		clr_cnt_d  = clr_cnt_q;
		go_clear_d = go_clear_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.item_load = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.op)
					OP_LETTER: begin
						cmd.letter_wr = 1'b1;
						state_d       = S_IDLE;
					end
					OP_EDGE: begin
						if (stat.node_ok) begin
							cmd.cnt_rd_edge = 1'b1;
							state_d         = S_EDGE;
						end else begin
							state_d = S_IDLE;
						end
					end
					OP_CHAR: begin
						cmd.node_first = 1'b1;
						state_d        = S_NODE_RD;
					end
					OP_CLEAR: begin
						cmd.clr_clr = 1'b1;
						clr_prev_d  = 1'b0;
						clr_cnt_d   = 1'b1;
						state_d     = S_CLEAR;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_EDGE: begin
				go_clear_d = 1'b0;
				priority if (stat.pred_bad) begin
					cmd.res_order = 1'b1;
					state_d       = S_EMIT;
				end else if (stat.cnt_full) begin
					cmd.res_full = 1'b1;
					state_d      = S_EMIT;
				end else begin
					cmd.edge_wr = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_NODE_RD: begin
				cmd.node_rd = 1'b1;
				state_d     = S_NODE_EVAL;
			end
			S_NODE_EVAL: begin
				cmd.node_eval = 1'b1;
				state_d       = stat.cnt_zero ? S_WRITE : S_PRED_RD;
			end
			S_PRED_RD: begin
				cmd.pred_rd = 1'b1;
				state_d     = S_PRED_EVAL;
			end
			S_PRED_EVAL: begin
				cmd.pred_eval = 1'b1;
				state_d       = S_ROW_EVAL;
			end
			S_ROW_EVAL: begin
				cmd.row_eval = 1'b1;
				state_d      = stat.k_last ? S_WRITE : S_PRED_RD;
			end
			S_WRITE: begin
				cmd.node_wr = 1'b1;
				if (!stat.j_last) begin
					cmd.node_next = 1'b1;
					state_d       = S_NODE_RD;
				end else if (stat.last) begin
					state_d = S_RESULT;
				end else begin
					cmd.copy_clr = 1'b1;
					state_d      = S_COPY;
				end
			end
			S_COPY: begin
				cmd.copy_step = 1'b1;
				if (stat.copy_done) begin
					cmd.rn_inc = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_RESULT: begin
				cmd.res_dist = 1'b1;
				cmd.rn_clr   = 1'b1;
				go_clear_d   = 1'b1;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					if (go_clear_q) begin
						cmd.clr_clr = 1'b1;
						clr_prev_d  = 1'b1;
						clr_cnt_d   = 1'b0;
						state_d     = S_CLEAR;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				cmd.clr_prev = clr_prev_q;
				cmd.clr_cnt  = clr_cnt_q;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state registers; reset starts with a full clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_prev_q <= 1'b1;
			clr_cnt_q  <= 1'b1;
			go_clear_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			clr_prev_q <= clr_prev_d;
			clr_cnt_q  <= clr_cnt_d;
			go_clear_q <= go_clear_d;
		end
	end

endmodule

>>> design/gsed_dp.sv
// Datapath for the graph sequence edit distance block: tables, row
// memories, counters, accumulator and output register.
// Depends on gsed_pkg for codes and the command/status structs.
module gsed_dp
	import gsed_pkg::*;
#(
	parameter int MAX_NODES  = 256,
	parameter int MAX_PREDS  = 4,
	parameter int DIST_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  gsed_cmd_t   cmd,
	output gsed_stat_t  stat,
	input  logic        cfg_wr,
	input  logic [8:0]  cfg_data,
	input  logic [1:0]  opcode,
	input  logic [7:0]  node_index,
	input  logic [7:0]  node_letter,
	input  logic [7:0]  pred_index,
	input  logic [7:0]  seq_char,
	input  logic        last_char,
	input  logic        out_stall,
	output logic        out_valid,
	output logic [15:0] min_distance,
	output logic [7:0]  end_node,
	output logic [1:0]  status
);

	localparam int NW   = $clog2(MAX_NODES);
	localparam int NCW  = $clog2(MAX_NODES + 1);
	localparam int CNTW = $clog2(MAX_PREDS + 1);
	localparam int PD   = MAX_NODES * MAX_PREDS;
	localparam int PAW  = $clog2(PD);
	localparam int DW   = DIST_WIDTH;
	localparam int DXW  = (DW > 16) ? DW : 16;
	localparam int WW   = (NW > 8) ? NW : 8;

	localparam logic [DW-1:0] DMAX = {DW{1'b1}};

	function automatic logic [DW-1:0] sat_inc(input logic [DW-1:0] v);
		return (v == DMAX) ? v : v + DW'(1);
	endfunction

	function automatic logic [DW-1:0] min2(input logic [DW-1:0] a, input logic [DW-1:0] b);
		return (b < a) ? b : a;
	endfunction

	// accepted item
	logic [1:0] op_q;
	logic [7:0] node_q, letter_in_q, pred_q, char_q;
	logic       last_q;

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			op_q        <= opcode;
			node_q      <= node_index;
			letter_in_q <= node_letter;
			pred_q      <= pred_index;
			char_q      <= seq_char;
			last_q      <= last_char;
		end
	end

	logic          node_ok;
	logic [NW-1:0] node_a;
	assign node_ok = 32'(node_q) < MAX_NODES;
	assign node_a  = NW'(node_q);

	// control registers
	logic [NCW-1:0] node_count_q;
	logic [15:0]    rn_q;
	logic [NW-1:0]  clr_q;
	logic           out_valid_q;
	logic [NCW-1:0] nc_clamp;

	always_comb begin
		priority if (cfg_data == 9'd0) begin
			nc_clamp = NCW'(1);
		end else if (32'(cfg_data) > MAX_NODES) begin
			nc_clamp = NCW'(MAX_NODES);
		end else begin
			nc_clamp = NCW'(cfg_data);
		end
	end

	// node count, row counter, clearing sweep, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NCW'(1);
			rn_q         <= '0;
			clr_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				node_count_q <= nc_clamp;
			end
			if (cmd.rn_clr) begin
				rn_q <= '0;
			end else if (cmd.rn_inc && rn_q != 16'hFFFF) begin
				rn_q <= rn_q + 16'd1;
			end
			if (cmd.clr_clr) begin
				clr_q <= '0;
			end else if (cmd.clr_step) begin
				clr_q <= clr_q + NW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// walk counters and accumulator state
	logic [NW-1:0]   j_q;
	logic [CNTW-1:0] k_q, cnt_q;
	logic [NCW-1:0]  c_q;
	logic [DW-1:0]   acc_q, best_q;
	logic [NW-1:0]   where_q;
	logic            match_q;

	// memory read data
	logic [7:0]      letter_rd_q;
	logic [CNTW-1:0] cnt_rd_q;
	logic [NW-1:0]   pred_rd_q;
	logic [DW-1:0]   prev_rd_q, cur_rd_q;

	// letter table
	logic [7:0] letter_mem [MAX_NODES];
	always_ff @(posedge clk) begin
		if (cmd.letter_wr && node_ok) begin
			letter_mem[node_a] <= letter_in_q;
		end
		if (cmd.node_rd) begin
			letter_rd_q <= letter_mem[j_q];
		end
	end

	// predecessor counts
	logic [CNTW-1:0] cnt_mem [MAX_NODES];
	logic            cnt_we;
	logic [NW-1:0]   cnt_wa, cnt_ra;
	logic [CNTW-1:0] cnt_wd;
	assign cnt_we = cmd.edge_wr || (cmd.clr_step && cmd.clr_cnt);
	assign cnt_wa = cmd.edge_wr ? node_a : clr_q;
	assign cnt_wd = cmd.edge_wr ? CNTW'(cnt_rd_q + CNTW'(1)) : '0;
	assign cnt_ra = cmd.cnt_rd_edge ? node_a : j_q;

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (cmd.cnt_rd_edge || cmd.node_rd) begin
			cnt_rd_q <= cnt_mem[cnt_ra];
		end
	end

	// predecessor table, MAX_PREDS slots per node
	logic [NW-1:0]  pred_mem [PD];
	logic [PAW-1:0] pred_wa, pred_ra;
	assign pred_wa = PAW'(PAW'(node_a) * PAW'(MAX_PREDS) + PAW'(cnt_rd_q));
	assign pred_ra = PAW'(PAW'(j_q) * PAW'(MAX_PREDS) + PAW'(k_q));

	always_ff @(posedge clk) begin
		if (cmd.edge_wr) begin
			pred_mem[pred_wa] <= NW'(pred_q);
		end
		if (cmd.pred_rd) begin
			pred_rd_q <= pred_mem[pred_ra];
		end
	end

	// previous row
	logic [DW-1:0] prev_mem [MAX_NODES];
	logic          copy_wr, prev_we;
	logic [NW-1:0] prev_wa, prev_ra;
	logic [DW-1:0] prev_wd;
	assign copy_wr = cmd.copy_step && (c_q != '0);
	assign prev_we = copy_wr || (cmd.clr_step && cmd.clr_prev);
	assign prev_wa = copy_wr ? NW'(c_q - NCW'(1)) : clr_q;
	assign prev_wd = copy_wr ? cur_rd_q : '0;
	assign prev_ra = cmd.node_rd ? j_q : pred_rd_q;

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		if (cmd.node_rd || cmd.pred_eval) begin
			prev_rd_q <= prev_mem[prev_ra];
		end
	end

	// current row
	logic [DW-1:0] cur_mem [MAX_NODES];
	logic          copy_rd;
	logic [NW-1:0] cur_ra;
	assign copy_rd = cmd.copy_step && (c_q != node_count_q);
	assign cur_ra  = cmd.pred_eval ? pred_rd_q : NW'(c_q);

	always_ff @(posedge clk) begin
		if (cmd.node_wr) begin
			cur_mem[j_q] <= acc_q;
		end
		if (cmd.pred_eval || copy_rd) begin
			cur_rd_q <= cur_mem[cur_ra];
		end
	end

	// per-node cost terms
	logic          match;
	logic [DW-1:0] row_clip, acc_init, acc_upd;
	assign match    = (char_q == letter_rd_q);
	assign row_clip = (32'(rn_q) > 32'(DMAX)) ? DMAX : DW'(rn_q);

	always_comb begin
		if (match) begin
			acc_init = (cnt_rd_q == '0) ? row_clip : DMAX;
		end else begin
			acc_init = sat_inc(prev_rd_q);
		end
		if (match_q) begin
			acc_upd = min2(acc_q, prev_rd_q);
		end else begin
			acc_upd = min2(min2(acc_q, sat_inc(prev_rd_q)), sat_inc(cur_rd_q));
		end
	end

	// advance node and predecessor walk, track row minimum
	always_ff @(posedge clk) begin
		if (cmd.node_first) begin
			j_q <= '0;
		end else if (cmd.node_next) begin
			j_q <= j_q + NW'(1);
		end
		if (cmd.node_eval) begin
			match_q <= match;
			cnt_q   <= cnt_rd_q;
			k_q     <= '0;
			acc_q   <= acc_init;
		end else if (cmd.row_eval) begin
			acc_q <= acc_upd;
			k_q   <= k_q + CNTW'(1);
		end
		if (cmd.node_wr && (j_q == '0 || acc_q < best_q)) begin
			best_q  <= acc_q;
			where_q <= j_q;
		end
		if (cmd.copy_clr) begin
			c_q <= '0;
		end else if (cmd.copy_step) begin
			c_q <= c_q + NCW'(1);
		end
	end

	// result and output registers
	logic [DXW-1:0] best_x;
	logic [WW-1:0]  where_x;
	logic [15:0]    res_dist_q;
	logic [7:0]     res_node_q;
	logic [1:0]     res_sts_q;
	assign best_x  = DXW'(best_q);
	assign where_x = WW'(where_q);

	always_ff @(posedge clk) begin
		priority if (cmd.res_dist) begin
			res_dist_q <= (best_x > DXW'(16'hFFFF)) ? 16'hFFFF : best_x[15:0];
			res_node_q <= where_x[7:0];
			res_sts_q  <= STS_READY;
		end else if (cmd.res_full) begin
			res_dist_q <= '0;
			res_node_q <= '0;
			res_sts_q  <= STS_FULL;
		end else if (cmd.res_order) begin
			res_dist_q <= '0;
			res_node_q <= '0;
			res_sts_q  <= STS_ORDER;
		end else begin
			res_sts_q <= res_sts_q;
		end
		if (cmd.out_load) begin
			min_distance <= res_dist_q;
			end_node     <= res_node_q;
			status       <= res_sts_q;
		end
	end

	assign out_valid = out_valid_q;

	// status to controller
	always_comb begin
		stat.op        = op_q;
		stat.node_ok   = node_ok;
		stat.pred_bad  = pred_q >= node_q;
		stat.cnt_full  = 32'(cnt_rd_q) >= MAX_PREDS;
		stat.cnt_zero  = (cnt_rd_q == '0);
		stat.k_last    = (CNTW'(k_q + CNTW'(1)) == cnt_q);
		stat.j_last    = (NCW'(NCW'(j_q) + NCW'(1)) == node_count_q);
		stat.last      = last_q;
		stat.copy_done = (c_q == node_count_q);
		stat.clr_last  = (clr_q == NW'(MAX_NODES - 1));
		stat.out_free  = !out_valid_q || !out_stall;
	end

endmodule

>>> design/graph_sequence_edit_distance_top.sv
// Top level of the graph sequence edit distance block: controller plus
// datapath. Depends on gsed_pkg, gsed_ctrl, gsed_dp and the defines header.
//
//   channel   handshake              payload
//   in        in_valid / in_stall    opcode node_index node_letter pred_index
//                                    seq_char last_char
//   out       out_valid / out_stall  min_distance end_node status
//   cfg       cfg_valid / cfg_ready  cfg_data (node_count)
//
// One transaction at a time. A clear-edges item sweeps all MAX_NODES
// predecessor counts to zero. A character walks every node in use and each
// of its edges over single-port predecessor and row memories; a non-last
// character then copies the current row into the previous row. The last
// character instead emits its result and sweeps all MAX_NODES entries to
// zero the row. After reset a clearing pass over all MAX_NODES entries
// holds in_stall high. A result waits in the output register under out_stall
// while the next item is taken.
`include "graph_sequence_edit_distance_top_defines.svh"

module graph_sequence_edit_distance_top
	import gsed_pkg::*;
#(
	parameter int MAX_NODES  = 256,
	parameter int MAX_PREDS  = 4,
	parameter int DIST_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [7:0]  node_index,
	input  logic [7:0]  node_letter,
	input  logic [7:0]  pred_index,
	input  logic [7:0]  seq_char,
	input  logic        last_char,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] min_distance,
	output logic [7:0]  end_node,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data
);

	gsed_cmd_t  cmd;
	gsed_stat_t stat;
	logic       idle;

	assign in_stall  = !idle;
	assign cfg_ready = 1'b1;

	gsed_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.idle     (idle),
		.cmd      (cmd)
	);

	gsed_dp #(
		.MAX_NODES  (MAX_NODES),
		.MAX_PREDS  (MAX_PREDS),
		.DIST_WIDTH (DIST_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_wr       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.opcode       (opcode),
		.node_index   (node_index),
		.node_letter  (node_letter),
		.pred_index   (pred_index),
		.seq_char     (seq_char),
		.last_char    (last_char),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.min_distance (min_distance),
		.end_node     (end_node),
		.status       (status)
	);

	// a taken transaction blocks the input for the next cycle
	`GSED_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "input not held after take")
	// a result only appears from a busy block
	`GSED_ASSERT_NOW(a_result_from_busy, $rose(out_valid), $past(in_stall), "result while idle")
	// a letter write returns the block to idle right after its decode state
	`GSED_ASSERT_NEXT(a_letter_quick, in_valid && !in_stall && opcode == OP_LETTER, ##1 !in_stall, "letter write too slow")

endmodule

>>> tb/gsed_distance_checker.sv
// Checker for the graph sequence edit distance block: watches the input,
// output and register channels, predicts every result and compares.
// Depends on gsed_pkg.
`timescale 1ns / 1ps

module gsed_distance_checker
	import gsed_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [7:0]  node_index,
	input  logic [7:0]  node_letter,
	input  logic [7:0]  pred_index,
	input  logic [7:0]  seq_char,
	input  logic        last_char,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] min_distance,
	input  logic [7:0]  end_node,
	input  logic [1:0]  status,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [8:0]  cfg_data,
	output int          mismatches,
	output int          pending
);

	localparam int NODES = 256;
	localparam int PREDS = 4;
	localparam int unsigned DIST_TOP = 65535;

	typedef struct packed {
		logic [15:0] dist_val;
		logic [7:0]  node;
		logic [1:0]  sts;
	} match_result_t;

	match_result_t distance_results[$];

	logic [7:0]  node_letters [NODES];
	logic [7:0]  node_preds   [NODES][PREDS];
	int unsigned node_pred_cnt[NODES];
	int unsigned row_prev     [NODES];
	int unsigned row_cur      [NODES];
	int unsigned row_index;
	int unsigned nodes_in_use;

	initial mismatches = 0;
	assign pending = distance_results.size();

	function automatic int unsigned sat_bump(input int unsigned v);
		return (v >= DIST_TOP) ? DIST_TOP : v + 1;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// Advance the alignment by one sequence character; emit a result on the last one
	task automatic align_character(input logic [7:0] ch, input logic fin);
		int unsigned v;
		int unsigned best;
		int unsigned where;
		int p;
		match_result_t r;
		for (int j = 0; j < nodes_in_use; j++) begin
			if (ch == node_letters[j]) begin
				if (node_pred_cnt[j] == 0) begin
					v = row_index;
				end else begin
					v = DIST_TOP;
					for (int k = 0; k < node_pred_cnt[j]; k++) begin
						p = node_preds[j][k];
						if (row_prev[p] < v) v = row_prev[p];
					end
				end
			end else begin
				v = sat_bump(row_prev[j]);
				for (int k = 0; k < node_pred_cnt[j]; k++) begin
					p = node_preds[j][k];
					if (sat_bump(row_prev[p]) < v) v = sat_bump(row_prev[p]);
					if (sat_bump(row_cur[p]) < v) v = sat_bump(row_cur[p]);
				end
			end
			row_cur[j] = v;
		end
		for (int j = 0; j < nodes_in_use; j++) row_prev[j] = row_cur[j];
		if (row_index < DIST_TOP) row_index++;
		if (fin) begin
			best = row_prev[0];
			where = 0;
			for (int j = 1; j < nodes_in_use; j++) begin
				if (row_prev[j] < best) begin
					best = row_prev[j];
					where = j;
				end
			end
			r.dist_val = best[15:0];
			r.node = where[7:0];
			r.sts = STS_READY;
			distance_results.push_back(r);
			for (int j = 0; j < NODES; j++) begin
				row_prev[j] = 0;
				row_cur[j] = 0;
			end
			row_index = 0;
		end
	endtask

	// Track the block: retire results first, then register writes, then new items
	always @(posedge clk or negedge arst_n) begin
		match_result_t r;
		match_result_t want;
		int unsigned n;
		if (!arst_n) begin
			for (int j = 0; j < NODES; j++) begin
				node_pred_cnt[j] = 0;
				row_prev[j] = 0;
				row_cur[j] = 0;
			end
			row_index = 0;
			nodes_in_use = 1;
			distance_results.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (distance_results.size() == 0) begin
					report_mismatch("unexpected result, distance", min_distance, -1);
				end else begin
					want = distance_results.pop_front();
					if (min_distance !== want.dist_val)
						report_mismatch("min_distance", min_distance, want.dist_val);
					if (end_node !== want.node)
						report_mismatch("end_node", end_node, want.node);
					if (status !== want.sts)
						report_mismatch("status", status, want.sts);
				end
			end
			if (cfg_valid && cfg_ready) begin
				n = cfg_data;
				if (n < 1) n = 1;
				if (n > NODES) n = NODES;
				nodes_in_use = n;
			end
			if (in_valid && !in_stall) begin
				r.dist_val = '0;
				r.node = '0;
				case (opcode)
					OP_LETTER: node_letters[node_index] = node_letter;
					OP_EDGE: begin
						if (pred_index >= node_index) begin
							r.sts = STS_ORDER;
							distance_results.push_back(r);
						end else if (node_pred_cnt[node_index] >= PREDS) begin
							r.sts = STS_FULL;
							distance_results.push_back(r);
						end else begin
							node_preds[node_index][node_pred_cnt[node_index]] = pred_index;
							node_pred_cnt[node_index]++;
						end
					end
					OP_CLEAR: for (int j = 0; j < NODES; j++) node_pred_cnt[j] = 0;
					default: align_character(seq_char, last_char);
				endcase
			end
		end
	end

endmodule

>>> tb/tb_graph_sequence_edit_distance_top.sv
// Testbench top for the graph sequence edit distance block: drives letters,
// edges, clears, sequences and node counts, and gives the verdict.
// Depends on gsed_pkg, the block and gsed_distance_checker.
`timescale 1ns / 1ps

module tb_graph_sequence_edit_distance_top;
	import gsed_pkg::*;

	localparam int CYCLE_LIMIT = 20000000;
	localparam int SETTLE      = 5000;
	localparam int ITEM_GOAL   = 580;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  opcode;
	logic [7:0]  node_index;
	logic [7:0]  node_letter;
	logic [7:0]  pred_index;
	logic [7:0]  seq_char;
	logic        last_char;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] min_distance;
	logic [7:0]  end_node;
	logic [1:0]  status;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [8:0]  cfg_data;

	int mismatches;
	int pending;
	int cycles;
	int items_sent;
	int nodes_now;
	int stall_left;
	bit quiet;

	graph_sequence_edit_distance_top uut (.*);

	gsed_distance_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_graph_sequence_edit_distance_top: FAIL");
			$finish;
		end
	end

	// Stall the result channel in random bursts, none near the end
	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 9) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 15);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Send one transaction, with an optional idle burst ahead of it
	task automatic send_item(input logic [1:0] op, input logic [7:0] node,
			input logic [7:0] letter, input logic [7:0] pred,
			input logic [7:0] ch, input logic fin);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		node_index <= node;
		node_letter <= letter;
		pred_index <= pred;
		seq_char <= ch;
		last_char <= fin;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// Write node_count once the block has drained
	task automatic set_nodes(input logic [8:0] value);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		nodes_now = (value == 0) ? 1 : (value > 256) ? 256 : value;
	endtask

	function automatic logic [7:0] pick_symbol();
		return ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
	endfunction

	task automatic send_sequence(input int len);
		for (int i = 0; i < len; i++)
			send_item(OP_CHAR, 8'($urandom), 8'($urandom), 8'($urandom), pick_symbol(),
				i == len - 1);
	endtask

	initial begin
		int len;
		int node;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_LETTER;
		node_index = '0;
		node_letter = '0;
		pred_index = '0;
		seq_char = '0;
		last_char = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		cycles = 0;
		items_sent = 0;
		nodes_now = 1;
		stall_left = 0;
		quiet = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Label every node so no unlabelled node is ever read
		send_item(OP_LETTER, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_item(OP_LETTER, 8'd1, 8'd255, 8'd0, 8'd0, 1'b0);
		for (int n = 2; n < 256; n++)
			send_item(OP_LETTER, 8'(n), pick_symbol(), 8'($urandom), 8'($urandom), 1'b0);

		// Single node: match and mismatch, extremes of the character
		send_item(OP_CHAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send_item(OP_CHAR, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
		send_item(OP_CHAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_item(OP_CHAR, 8'd0, 8'd0, 8'd0, 8'd255, 1'b1);

		// Small graph: good edges, order rejects, full table
		set_nodes(9'd8);
		send_item(OP_EDGE, 8'd1, 8'd0, 8'd0, 8'd0, 1'b0);
		send_item(OP_EDGE, 8'd2, 8'd0, 8'd1, 8'd0, 1'b0);
		send_item(OP_EDGE, 8'd3, 8'd0, 8'd3, 8'd0, 1'b0);
		send_item(OP_EDGE, 8'd0, 8'd0, 8'd5, 8'd0, 1'b0);
		for (int k = 0; k < 4; k++)
			send_item(OP_EDGE, 8'd4, 8'd0, 8'(k), 8'd0, 1'b0);
		send_item(OP_EDGE, 8'd4, 8'd0, 8'd3, 8'd0, 1'b0);
		send_item(OP_EDGE, 8'd4, 8'd0, 8'd200, 8'd0, 1'b0);
		send_item(OP_EDGE, 8'd255, 8'd0, 8'd254, 8'd0, 1'b0);
		send_item(OP_EDGE, 8'd255, 8'd0, 8'd255, 8'd0, 1'b0);
		send_sequence(3);

		// Node count grows in the middle of a sequence
		send_item(OP_CHAR, 8'd0, 8'd0, 8'd0, 8'd1, 1'b0);
		set_nodes(9'd511);
		send_item(OP_CHAR, 8'd0, 8'd0, 8'd0, 8'd2, 1'b1);
		send_item(OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_sequence(2);
		set_nodes(9'd0);
		send_sequence(2);

		// Random phases: mostly small graphs with well-formed edges
		while (items_sent < ITEM_GOAL) begin
			if (items_sent > ITEM_GOAL - 60) quiet = 1'b1;
			if ($urandom_range(0, 11) == 0)
				set_nodes($urandom_range(0, 1) ? 9'd256 : 9'($urandom_range(257, 511)));
			else
				set_nodes(9'($urandom_range(1, 24)));
			if ($urandom_range(0, 2) == 0)
				send_item(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
					1'($urandom));
			repeat ($urandom_range(0, 8)) begin
				node = $urandom_range(1, nodes_now > 1 ? nodes_now - 1 : 1);
				if ($urandom_range(0, 5) == 0)
					send_item(OP_EDGE, 8'(node), 8'($urandom), 8'($urandom), 8'($urandom),
						1'($urandom));
				else
					send_item(OP_EDGE, 8'(node), 8'($urandom), 8'($urandom_range(0, node - 1)),
						8'($urandom), 1'($urandom));
			end
			if ($urandom_range(0, 3) == 0)
				send_item(OP_LETTER, 8'($urandom), pick_symbol(), 8'($urandom), 8'($urandom),
					1'($urandom));
			len = (nodes_now > 64) ? $urandom_range(1, 2) : $urandom_range(1, 6);
			repeat ($urandom_range(1, 3)) send_sequence(len);
		end

		in_valid <= 1'b0;
		quiet = 1'b1;
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("tb_graph_sequence_edit_distance_top: PASS");
		else
			$display("tb_graph_sequence_edit_distance_top: FAIL");
		$finish;
	end

endmodule
